// ===== hw/rtl/ahts_pkg.sv =====
// ahts_pkg: constants, coefficient tables and the sine lookup for the
// additive harmonic tone synthesizer. No dependencies.
package ahts_pkg;

    localparam int SINE_ADDR_BITS = 10;
    localparam int PHASE_BITS     = 32;
    localparam int QUARTER_BITS   = SINE_ADDR_BITS - 2;
    localparam int QUARTER_LEN    = 1 << QUARTER_BITS;
    localparam int NUM_PARTIALS   = 10;

    localparam int STEP_W     = 32;
    localparam int IDX_W      = 24;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int SAMPLE_W   = 8;
    localparam int TDATA_W    = 8;
    localparam int SINE_W     = 16;
    localparam int WEIGHT_W   = 16;
    localparam int MULT_W     = 9;

    // y + 3 in Q3.29 always lies in (0, 6), so 32 bits hold it unsigned
    localparam int ACC_W      = 32;
    localparam int SUM_W      = 34;
    localparam int GAIN_W     = 6;
    localparam int SCALED_W   = ACC_W + GAIN_W;
    localparam int OUT_SHIFT  = 29;
    localparam int VAL_W      = SCALED_W - OUT_SHIFT;

    localparam logic [SUM_W-1:0]    OFFSET_Q29 = SUM_W'(3) << OUT_SHIFT;
    localparam logic [GAIN_W-1:0]   OUT_GAIN   = GAIN_W'(50);
    localparam logic [SCALED_W-1:0] ROUND_HALF = SCALED_W'(1) << (OUT_SHIFT - 1);
    localparam logic [VAL_W-1:0]    SAMPLE_MAX = VAL_W'(255);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE_STEP  = 1'b0,
        REG_TONE_LENGTH = 1'b1
    } cfg_reg_t;

    // partial frequency as a multiple of F/60, and its weight in Q2.14
    localparam logic [MULT_W-1:0] PARTIAL_MULT [NUM_PARTIALS] = '{
        9'd60, 9'd30, 9'd20, 9'd15, 9'd12, 9'd120, 9'd180, 9'd240, 9'd300, 9'd360
    };
    localparam logic signed [WEIGHT_W-1:0] PARTIAL_WEIGHT [NUM_PARTIALS] = '{
        16'sd16384, 16'sd164, 16'sd164, 16'sd819, 16'sd3277,
        16'sd4915, 16'sd3277, 16'sd3277, 16'sd3277, 16'sd2458
    };

    // quarter-wave table, built at elaboration from an integer taylor series
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] SERIES_DIV [1:9] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342
    };

    typedef logic [SINE_W-2:0] quarter_tab_t [QUARTER_LEN];

    function automatic logic [SINE_W-2:0] series_sin(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [65:0] sum;
        logic [63:0]        v;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed({2'b00, x});
        for (int k = 1; k <= 9; k++)
        begin
            term = ((term * x2) >> 30) / SERIES_DIV[k];
            if (k[0])
                sum = sum - $signed({2'b00, term});
            else
                sum = sum + $signed({2'b00, term});
        end
        if (sum < 0)
            sum = '0;
        v = (64'(sum) + 64'd16384) >> 15;
        if (v > 64'd32767)
            v = 64'd32767;
        return v[SINE_W-2:0];
    endfunction

    function automatic quarter_tab_t build_quarter();
        quarter_tab_t t;
        for (int r = 0; r < QUARTER_LEN; r++)
            t[r] = series_sin((HALF_PI_Q30 * 64'(r)) >> QUARTER_BITS);
        return t;
    endfunction

    localparam quarter_tab_t      QUARTER_TAB  = build_quarter();
    // the entry at a full quarter turn sits outside the table
    localparam logic [SINE_W-2:0] QUARTER_PEAK = series_sin(HALF_PI_Q30);

    // full-wave sine in Q1.15 from quarter-wave symmetry
    function automatic logic signed [SINE_W-1:0] sine_lookup(
        input logic [SINE_ADDR_BITS-1:0] addr
    );
        logic [QUARTER_BITS-1:0] r;
        logic [QUARTER_BITS-1:0] r_mirror;
        logic [SINE_W-2:0]       mag;
        r        = addr[QUARTER_BITS-1:0];
        r_mirror = ~r + 1'b1;
        if (!addr[QUARTER_BITS])
            mag = QUARTER_TAB[r];
        else if (r == '0)
            mag = QUARTER_PEAK;
        else
            mag = QUARTER_TAB[r_mirror];
        if (addr[QUARTER_BITS+1])
            return -$signed({1'b0, mag});
        else
            return $signed({1'b0, mag});
    endfunction

endpackage

// ===== hw/rtl/additive_harmonic_tone_synth.sv =====
// additive_harmonic_tone_synth: top level, phase accumulator and the
// four-stage sample pipeline. Depends on ahts_pkg.
//
//  channel   | dir | handshake               | payload
//  ----------+-----+-------------------------+-----------------------------------
//  s_axis    | in  | tvalid / tready         | tdata[0] start_tone, [7:1] zero
//  m_axis    | out | tvalid / tready         | tdata[7:0] sample, tuser[0] clipped,
//            |     |                         | tlast tone_end
//  cfg       | in  | cfg_we, no wait         | cfg_index, cfg_data
//
// one request enters per cycle unless a stall fills every stage; it passes the
// stages in turn: phase register, sine lookup, weighted sum, scale and saturate
// each stage moves on when the one after it is empty or moving, so bubbles
// collapse and input keeps flowing until the stages behind a waiting sample fill
// s_axis_tready follows m_axis_tready combinationally through the stage enables
// rst_n clears the phase accumulator, sample count, cfg registers and all valids
module additive_harmonic_tone_synth (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [ahts_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ahts_pkg::CFG_DATA_W-1:0]     cfg_data,
    // request stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [ahts_pkg::TDATA_W-1:0]        s_axis_tdata,   // [0] start_tone
    // sample stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [ahts_pkg::TDATA_W-1:0]        m_axis_tdata,   // [7:0] sample
    output logic                                m_axis_tuser,   // [0] clipped
    output logic                                m_axis_tlast    // tone_end
);
    import ahts_pkg::*;

    // configuration registers
    logic [STEP_W-1:0]     phase_step_reg;
    logic [IDX_W-1:0]      tone_length_reg;

    // running state
    logic [PHASE_BITS-1:0] base_phase_reg, base_phase_next;
    logic [IDX_W-1:0]      sample_index_reg, sample_index_next;

    // stage valids and enables
    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic en1, en2, en3, eno;
    logic accept;

    // stage payloads
    logic [PHASE_BITS-1:0]          ph1_reg;
    logic                           end1_reg, end2_reg, end3_reg, endo_reg;
    logic signed [SINE_W-1:0]       sine2_reg [NUM_PARTIALS];
    logic signed [SINE_W-1:0]       sine2_next [NUM_PARTIALS];
    logic [ACC_W-1:0]               acc3_reg, acc3_next;
    logic [SAMPLE_W-1:0]            sample_reg, sample_next;
    logic                           clip_reg, clip_next;

    logic [PHASE_BITS-1:0]          phase_eff;
    logic [IDX_W-1:0]               index_eff;
    logic                           tone_end_eff;
    logic                           start_tone;

    // enables ripple back from the output
    assign eno    = !vo_reg || m_axis_tready;
    assign en3    = !v3_reg || eno;
    assign en2    = !v2_reg || en3;
    assign en1    = !v1_reg || en2;
    assign accept = s_axis_tvalid && en1;

    assign s_axis_tready = en1;
    assign m_axis_tvalid = vo_reg;
    assign m_axis_tdata  = TDATA_W'(sample_reg);
    assign m_axis_tuser  = clip_reg;
    assign m_axis_tlast  = endo_reg;

    // start flag restarts phase and count before this sample
    assign start_tone   = s_axis_tdata[0];
    assign phase_eff    = start_tone ? '0 : base_phase_reg;
    assign index_eff    = start_tone ? '0 : sample_index_reg;
    assign tone_end_eff = (tone_length_reg != '0) && (index_eff == tone_length_reg - 1'b1);

    assign base_phase_next   = phase_eff + PHASE_BITS'(phase_step_reg);
    assign sample_index_next = index_eff + 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg  <= '0;
            tone_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PHASE_STEP:  phase_step_reg  <= STEP_W'(cfg_data);
                REG_TONE_LENGTH: tone_length_reg <= IDX_W'(cfg_data);
                default:         ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_phase_reg   <= '0;
            sample_index_reg <= '0;
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            vo_reg           <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                base_phase_reg   <= base_phase_next;
                sample_index_reg <= sample_index_next;
            end
            if (en1)
                v1_reg <= s_axis_tvalid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (eno)
                vo_reg <= v3_reg;
        end
    end

    // partial phases and sine lookup
    always_comb
    begin
        logic [PHASE_BITS-1:0] p;
        for (int i = 0; i < NUM_PARTIALS; i++)
        begin
            p             = PHASE_BITS'(ph1_reg * PARTIAL_MULT[i]);
            sine2_next[i] = sine_lookup(p[PHASE_BITS-1 -: SINE_ADDR_BITS]);
        end
    end

    // weighted sum of partials plus the offset of three
    always_comb
    begin
        logic signed [SUM_W-1:0] sum;
        sum = $signed(OFFSET_Q29);
        for (int i = 0; i < NUM_PARTIALS; i++)
            sum = sum + SUM_W'(sine2_reg[i] * PARTIAL_WEIGHT[i]);
        acc3_next = ACC_W'(sum);
    end

    // times fifty, round half up, saturate
    always_comb
    begin
        logic [SCALED_W-1:0] scaled;
        logic [VAL_W-1:0]    val;
        scaled = SCALED_W'(acc3_reg) * SCALED_W'(OUT_GAIN) + ROUND_HALF;
        val    = scaled[SCALED_W-1:OUT_SHIFT];
        if (val > SAMPLE_MAX)
        begin
            sample_next = '1;
            clip_next   = 1'b1;
        end
        else
        begin
            sample_next = SAMPLE_W'(val);
            clip_next   = 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            ph1_reg  <= phase_eff;
            end1_reg <= tone_end_eff;
        end
        if (en2)
        begin
            sine2_reg <= sine2_next;
            end2_reg  <= end1_reg;
        end
        if (en3)
        begin
            acc3_reg <= acc3_next;
            end3_reg <= end2_reg;
        end
        if (eno)
        begin
            sample_reg <= sample_next;
            clip_reg   <= clip_next;
            endo_reg   <= end3_reg;
        end
    end

endmodule

// ===== hw/rtl/ahts_checker.sv =====
// ahts_checker: port-level assertions for the tone synthesizer, bound to
// the top level. No package dependency.
module ahts_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tuser,
    input logic       m_axis_tlast
);

    // a stalled sample holds its request
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled sample changed");

    // clip flag only on a saturated sample
    a_clip_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'hFF)
        else $error("clip flag without full-scale sample");

    // input never stalls while the output can move
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
        else $error("input stalled with free output");

endmodule

bind additive_harmonic_tone_synth ahts_checker u_ahts_checker (.*);
